/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold whenever ante holds, outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

// expr must never be true, outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("assertion failed: forbidden condition seen");

`endif

/* rtl/scma_pkg.sv */
// ----------------------------------------------------------------------------
// scma_pkg
// constants, types and helpers of the sparse coordinate merge-add unit
// ----------------------------------------------------------------------------
package scma_pkg;

    localparam int MAX_MODES  = 4;
    localparam int INDEX_BITS = 32;
    localparam int VALUE_BITS = 32;
    localparam int MODE_BITS  = 3;

    // stream beat: indices from mode 0 up, then the value, padded to bytes
    localparam int PAYLOAD_BITS = MAX_MODES * INDEX_BITS + VALUE_BITS;
    localparam int DATA_BITS    = ((PAYLOAD_BITS + 7) / 8) * 8;
    localparam int VALUE_LSB    = MAX_MODES * INDEX_BITS;

    // result tuser bit positions
    localparam int OUT_USER_BITS  = 3;
    localparam int USER_HAS_ELEM  = 0;
    localparam int USER_NEXT_SRC  = 1;
    localparam int USER_PROTO_ERR = 2;

    // stream select codes
    localparam logic SRC_FIRST  = 1'b0;
    localparam logic SRC_SECOND = 1'b1;

    // configuration
    localparam int                   APB_ADDR_BITS   = 3;
    localparam logic [MODE_BITS-1:0] MODES_RESET     = MODE_BITS'(1);
    localparam logic [MODE_BITS-1:0] MODES_MAX_CODE  = MODE_BITS'(MAX_MODES);
    localparam logic                 REG_ACTIVE_MODES = 1'b0;

    typedef logic        [INDEX_BITS-1:0] t_index;
    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef t_index                       t_coord [MAX_MODES];

    // zero acts as one, anything above the mode count acts as the mode count
    function automatic logic [MODE_BITS-1:0] clamp_modes(input logic [MODE_BITS-1:0] raw);
        logic [MODE_BITS-1:0] res;
        if (raw == '0) begin
            res = MODE_BITS'(1);
        end else if (raw > MODES_MAX_CODE) begin
            res = MODES_MAX_CODE;
        end else begin
            res = raw;
        end
        return res;
    endfunction

    function automatic t_value sat_add(input t_value a, input t_value b);
        logic signed [VALUE_BITS:0] sum;
        t_value                     res;
        sum = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
        if (sum[VALUE_BITS] != sum[VALUE_BITS-1]) begin
            res = sum[VALUE_BITS] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                  : {1'b0, {(VALUE_BITS-1){1'b1}}};
        end else begin
            res = sum[VALUE_BITS-1:0];
        end
        return res;
    endfunction

endpackage

/* rtl/sparse_coo_merge_add_unit.sv */
// ----------------------------------------------------------------------------
// sparse_coo_merge_add_unit
// merge-add of two sorted coordinate streams into one sorted stream
// ----------------------------------------------------------------------------
// Both tensors come in on one input channel; tuser picks the stream and
// tlast marks its end beat, which carries no element. The block asks for the
// next beat on o_m_tuser[1] (next source); a beat from the other stream is
// answered with the error flag and dropped. Every accepted beat gives exactly
// one result beat: a merged element (smaller head, or the saturated sum on
// equal coordinates, zero values dropped) or an empty beat; tlast on the
// result marks the merge as done. active_modes (APB, address 0) sets how many
// index modes are compared; the user must write it only while the block is
// idle, and the block itself does not enforce this. An input beat enters the
// input register, then the head update, compare and add land in the result
// register. Throughput is one beat per cycle unless the receiver stalls, set
// by the head register update loop. When the receiver stalls, one more beat
// is taken into the input register, then o_s_tready drops until the result
// register drains. Reset clears both heads, the end flags and the request
// (first stream) and sets active_modes to 1; only reset starts a new merge.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sparse_coo_merge_add_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input stream
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [scma_pkg::DATA_BITS-1:0]        i_s_tdata,  // index_0..3, value
    input  logic                                  i_s_tuser,  // source
    input  logic                                  i_s_tlast,  // end of stream
    // result stream
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [scma_pkg::DATA_BITS-1:0]        o_m_tdata,  // index_0..3, value
    output logic [scma_pkg::OUT_USER_BITS-1:0]    o_m_tuser,  // has_element, next_source,
                                                              // protocol_error
    output logic                                  o_m_tlast,  // merge done
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [scma_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import scma_pkg::*;

    // configuration
    logic [MODE_BITS-1:0] r_active_modes;
    logic [MODE_BITS-1:0] modes;

    // input register
    logic   r_in_valid;
    logic   r_in_src;
    logic   r_in_end;
    t_coord r_in_idx;
    t_value r_in_val;

    // merge state
    logic   r_first_valid, r_second_valid;
    logic   r_first_ended, r_second_ended;
    logic   r_wanted;
    t_coord r_first_idx, r_second_idx;
    t_value r_first_val, r_second_val;

    logic   n_first_valid, n_second_valid;
    logic   n_first_ended, n_second_ended;
    logic   n_wanted;
    t_coord n_first_idx, n_second_idx;
    t_value n_first_val, n_second_val;

    // result register
    logic   r_out_valid;
    logic   r_out_has, r_out_done, r_out_next, r_out_err;
    t_coord r_out_idx;
    t_value r_out_val;

    logic   n_out_has, n_out_done, n_out_err;
    t_coord n_out_idx;
    t_value n_out_val;

    logic   fire;
    logic   done_now;
    logic   lt, gt;
    logic   pick_first, pick_second, pick_sum;
    t_value emit_val;

    assign fire       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || fire;
    assign modes      = clamp_modes(r_active_modes);

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_modes <= MODES_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[APB_ADDR_BITS-1] == REG_ACTIVE_MODES) begin
            r_active_modes <= pwdata[MODE_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_BITS-1] == REG_ACTIVE_MODES) begin
            prdata[MODE_BITS-1:0] = r_active_modes;
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_src <= i_s_tuser;
            r_in_end <= i_s_tlast;
            for (int m = 0; m < MAX_MODES; m++) begin
                r_in_idx[m] <= i_s_tdata[m*INDEX_BITS +: INDEX_BITS];
            end
            r_in_val <= i_s_tdata[VALUE_LSB +: VALUE_BITS];
        end
    end

    // ---------------- merge step ----------------
    always_comb begin
        n_first_valid  = r_first_valid;
        n_second_valid = r_second_valid;
        n_first_ended  = r_first_ended;
        n_second_ended = r_second_ended;
        n_first_idx    = r_first_idx;
        n_second_idx   = r_second_idx;
        n_first_val    = r_first_val;
        n_second_val   = r_second_val;
        n_wanted       = r_wanted;
        lt             = 1'b0;
        gt             = 1'b0;
        pick_first     = 1'b0;
        pick_second    = 1'b0;
        pick_sum       = 1'b0;
        emit_val       = '0;
        n_out_has      = 1'b0;
        n_out_idx      = '{default: '0};
        n_out_val      = '0;

        done_now  = r_first_ended && r_second_ended && !r_first_valid && !r_second_valid;
        n_out_err = done_now || (r_in_src != r_wanted);

        if (!n_out_err) begin
            // take the beat into its head
            if (r_in_end) begin
                if (r_in_src == SRC_SECOND) begin
                    n_second_ended = 1'b1;
                end else begin
                    n_first_ended = 1'b1;
                end
            end else if (r_in_src == SRC_SECOND) begin
                n_second_idx   = r_in_idx;
                n_second_val   = r_in_val;
                n_second_valid = 1'b1;
            end else begin
                n_first_idx   = r_in_idx;
                n_first_val   = r_in_val;
                n_first_valid = 1'b1;
            end

            // lexicographic compare, lower modes override, so mode 0 is most significant
            for (int m = MAX_MODES - 1; m >= 0; m--) begin
                if (m < int'(modes)) begin
                    if (n_first_idx[m] < n_second_idx[m]) begin
                        lt = 1'b1;
                        gt = 1'b0;
                    end else if (n_first_idx[m] > n_second_idx[m]) begin
                        lt = 1'b0;
                        gt = 1'b1;
                    end
                end
            end

            if (n_first_valid && n_second_valid) begin
                pick_first  = lt;
                pick_second = gt;
                pick_sum    = !lt && !gt;
            end else if (n_first_valid && n_second_ended) begin
                pick_first = 1'b1;
            end else if (n_second_valid && n_first_ended) begin
                pick_second = 1'b1;
            end

            if (pick_sum) begin
                emit_val = sat_add(n_first_val, n_second_val);
            end else if (pick_second) begin
                emit_val = n_second_val;
            end else if (pick_first) begin
                emit_val = n_first_val;
            end

            if (pick_first || pick_sum) begin
                n_first_valid = 1'b0;
            end
            if (pick_second || pick_sum) begin
                n_second_valid = 1'b0;
            end

            // zero elements are dropped
            n_out_has = emit_val != '0;
            if (n_out_has) begin
                n_out_val = emit_val;
                for (int m = 0; m < MAX_MODES; m++) begin
                    if (m < int'(modes)) begin
                        n_out_idx[m] = pick_second ? n_second_idx[m] : n_first_idx[m];
                    end
                end
            end

            if (!n_first_valid && !n_first_ended) begin
                n_wanted = SRC_FIRST;
            end else if (!n_second_valid && !n_second_ended) begin
                n_wanted = SRC_SECOND;
            end else begin
                n_wanted = SRC_FIRST;
            end
        end

        n_out_done = n_first_ended && n_second_ended && !n_first_valid && !n_second_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_valid  <= 1'b0;
            r_second_valid <= 1'b0;
            r_first_ended  <= 1'b0;
            r_second_ended <= 1'b0;
            r_wanted       <= SRC_FIRST;
        end else if (fire) begin
            r_first_valid  <= n_first_valid;
            r_second_valid <= n_second_valid;
            r_first_ended  <= n_first_ended;
            r_second_ended <= n_second_ended;
            r_wanted       <= n_wanted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_first_idx  <= n_first_idx;
            r_second_idx <= n_second_idx;
            r_first_val  <= n_first_val;
            r_second_val <= n_second_val;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_has  <= n_out_has;
            r_out_idx  <= n_out_idx;
            r_out_val  <= n_out_val;
            r_out_done <= n_out_done;
            r_out_next <= n_wanted;
            r_out_err  <= n_out_err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_done;

    always_comb begin
        o_m_tdata = '0;
        for (int m = 0; m < MAX_MODES; m++) begin
            o_m_tdata[m*INDEX_BITS +: INDEX_BITS] = r_out_idx[m];
        end
        o_m_tdata[VALUE_LSB +: VALUE_BITS] = r_out_val;

        o_m_tuser                 = '0;
        o_m_tuser[USER_HAS_ELEM]  = r_out_has;
        o_m_tuser[USER_NEXT_SRC]  = r_out_next;
        o_m_tuser[USER_PROTO_ERR] = r_out_err;
    end

    // ---------------- assertions ----------------
    // after every step at most one head is left waiting
    `ASSERT_NEVER(a_one_head_held, i_clk, i_rst_n, r_first_valid && r_second_valid)
    // the second stream is asked for only while its head is empty and open
    `ASSERT_IMPL(a_want_second, i_clk, i_rst_n, r_wanted == SRC_SECOND,
                 !r_second_valid && !r_second_ended)
    // an emitted element never carries a zero value
    `ASSERT_IMPL(a_no_zero_elem, i_clk, i_rst_n, r_out_valid && r_out_has, r_out_val != '0)
    // an ignored beat leaves the end flags and the request untouched
    `ASSERT_IMPL(a_err_keeps_state, i_clk, i_rst_n, fire && n_out_err,
                 ##1 (r_first_ended == $past(r_first_ended)
                      && r_second_ended == $past(r_second_ended)
                      && r_wanted == $past(r_wanted)))

endmodule
